/* hw/rtl/taycos_pkg.sv */
// ----------------------------------------------------------------------------
// taycos_pkg
// Shared constants, pipeline record and helper functions for the Taylor
// series cosine pipeline.
// ----------------------------------------------------------------------------
package taycos_pkg;

    localparam int MAX_TERMS = 16;
    localparam int FRAC_BITS = 28;
    localparam int TERM_W    = 33;            // term magnitude, <= 2^32
    localparam int PROD_W    = 37;            // term * x^2, <= 2^36
    localparam int RECIP_W   = FRAC_BITS;     // largest reciprocal is 2^27
    localparam int SUM_W     = 36;
    localparam int THR_W     = 52;            // 2^28 * 10^7 < 2^52
    localparam int MAG_W     = 31;            // |x| <= 2^30
    localparam int USED_W    = 5;
    localparam int PIPE_LAT  = 2 * MAX_TERMS + 3;

    localparam logic [63:0] RND      = 64'd1 << (FRAC_BITS - 1);
    localparam logic [MAG_W-1:0] MAG_MAX = MAG_W'(1) << 30;
    localparam logic signed [SUM_W-1:0] ONE_Q = SUM_W'(1) << FRAC_BITS;

    typedef struct packed {
        logic                     valid;
        logic [TERM_W-1:0]        x2;
        logic [PROD_W-1:0]        term;
        logic signed [SUM_W-1:0]  sum;
        logic [USED_W-1:0]        used;
        logic                     done;
    } pipe_t;

    // round(2^28 * 10^p), p is the 4-bit signed exponent code
    function automatic logic [THR_W-1:0] thr_lut(input logic [3:0] p);
        logic [THR_W-1:0] t;
        case (p)
            4'd0:    t = THR_W'(64'd268435456);
            4'd1:    t = THR_W'(64'd2684354560);
            4'd2:    t = THR_W'(64'd26843545600);
            4'd3:    t = THR_W'(64'd268435456000);
            4'd4:    t = THR_W'(64'd2684354560000);
            4'd5:    t = THR_W'(64'd26843545600000);
            4'd6:    t = THR_W'(64'd268435456000000);
            4'd7:    t = THR_W'(64'd2684354560000000);
            4'd8:    t = THR_W'(64'd3);
            4'd9:    t = THR_W'(64'd27);
            4'd10:   t = THR_W'(64'd268);
            4'd11:   t = THR_W'(64'd2684);
            4'd12:   t = THR_W'(64'd26844);
            4'd13:   t = THR_W'(64'd268435);
            4'd14:   t = THR_W'(64'd2684355);
            default: t = THR_W'(64'd26843546);
        endcase
        return t;
    endfunction

    // fold term number idx (held in rec.term) into the running sum, unless rec.done is already set
    function automatic pipe_t add_term(input pipe_t rec, input logic [USED_W-1:0] idx,
                                       input logic [THR_W-1:0] thr);
        pipe_t r;
        logic signed [SUM_W-1:0] t;
        r = rec;
        t = SUM_W'(rec.term);
        if (!rec.done) begin
            r.sum  = idx[0] ? rec.sum - t : rec.sum + t;
            r.used = idx;
            r.done = (THR_W'(rec.term) <= thr);
        end
        return r;
    endfunction

endpackage

/* hw/rtl/taylor_cosine_converge_top.sv */
// ----------------------------------------------------------------------------
// taylor_cosine_converge_top
// Cosine of a Q3.28 angle by Taylor series, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Pulse start with angle; an item is taken when start is high and busy is
//   low. busy is always low: one item may enter every cycle.
//   Each result shows on cosine / terms_used / not_converged for one cycle
//   with valid high. Results leave in order, one per cycle at most.
//   Stages: angle magnitude, x^2, then per term one multiply by x^2 and one
//   by the reciprocal constant; each term is folded into the sum in the
//   stage that follows it. Throughput is one item per cycle, set by the
//   one-multiplier-per-stage pipeline.
//   precision_exponent is written with cfg_wr_en / cfg_wr_data; write it
//   only while no item is in flight. Reset value is -3.
//   Reset clears all valid bits; items in flight are dropped.
//   The receiver cannot stall; there is no back-pressure.
// ----------------------------------------------------------------------------
module taylor_cosine_converge_top
    import taycos_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  angle,
    input  logic                cfg_wr_en,
    input  logic signed [3:0]   cfg_wr_data,
    output logic                valid,
    output logic signed [29:0]  cosine,
    output logic [4:0]          terms_used,
    output logic                not_converged
);

    logic [3:0]        prec_reg;
    logic [THR_W-1:0]  thr;
    logic              s0_vld_reg;
    logic [MAG_W-1:0]  s0_mag_reg;
    logic [32:0]       abs_ang;
    logic [MAG_W-1:0]  mag_next;
    pipe_t             s1_reg;
    pipe_t             a_reg [1:MAX_TERMS];
    pipe_t             b_reg [1:MAX_TERMS];
    pipe_t             fin;
    logic signed [SUM_W-1:0] clamped;
    logic              out_vld_reg;
    logic signed [29:0] cos_reg;
    logic [4:0]        used_reg;
    logic              nc_reg;

    assign busy = 1'b0;
    assign thr  = thr_lut(prec_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prec_reg <= 4'b1101;
        else if (cfg_wr_en)
            prec_reg <= cfg_wr_data;
    end

    always_comb
    begin
        abs_ang  = angle[31] ? 33'd0 - {angle[31], angle} : {1'b0, angle};
        mag_next = (abs_ang > 33'(MAG_MAX)) ? MAG_MAX : abs_ang[MAG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_vld_reg <= 1'b0;
        else
            s0_vld_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s0_mag_reg <= mag_next;
    end

    // x^2 and seed of the series
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_reg <= '0;
        else
        begin
            logic [63:0] sq;
            sq = 64'(s0_mag_reg) * 64'(s0_mag_reg) + RND;
            s1_reg.valid <= s0_vld_reg;
            s1_reg.x2    <= sq[FRAC_BITS +: TERM_W];
            s1_reg.term  <= PROD_W'(1) << FRAC_BITS;
            s1_reg.sum   <= ONE_Q;
            s1_reg.used  <= '0;
            s1_reg.done  <= 1'b0;
        end
    end

    for (genvar i = 1; i <= MAX_TERMS; i++)
    begin : g_term
        localparam longint DEN = longint'(2 * i - 1) * longint'(2 * i);
        localparam logic [RECIP_W-1:0] RC =
            RECIP_W'(((longint'(1) << FRAC_BITS) + DEN / 2) / DEN);
        pipe_t prev;

        // fold the previous term into the sum while the next one is built; the first term takes the seed as it is
        if (i == 1)
        begin : g_first
            assign prev = s1_reg;
        end
        else
        begin : g_rest
            assign prev = add_term(b_reg[i-1], USED_W'(i - 1), thr);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                a_reg[i] <= '0;
            else
            begin
                logic [79:0] p;
                pipe_t       a_next;
                p = 80'(prev.term) * 80'(prev.x2) + 80'(RND);
                a_next      = prev;
                a_next.term = p[FRAC_BITS +: PROD_W];
                a_reg[i]   <= a_next;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                b_reg[i] <= '0;
            else
            begin
                logic [79:0] q;
                pipe_t       b_next;
                q = 80'(a_reg[i].term) * 80'(RC) + 80'(RND);
                b_next      = a_reg[i];
                b_next.term = PROD_W'(q[FRAC_BITS +: TERM_W]);
                b_reg[i]   <= b_next;
            end
        end
    end

    always_comb
    begin
        fin = add_term(b_reg[MAX_TERMS], USED_W'(MAX_TERMS), thr);
        if (fin.sum > ONE_Q)
            clamped = ONE_Q;
        else if (fin.sum < -ONE_Q)
            clamped = -ONE_Q;
        else
            clamped = fin.sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= fin.valid;
    end

    always_ff @(posedge clk)
    begin
        cos_reg  <= clamped[29:0];
        used_reg <= fin.used;
        nc_reg   <= !fin.done;
    end

    assign valid         = out_vld_reg;
    assign cosine        = cos_reg;
    assign terms_used    = used_reg;
    assign not_converged = nc_reg;

endmodule

/* hw/rtl/taycos_chk.sv */
// ----------------------------------------------------------------------------
// taycos_chk
// Port-level checks for the cosine pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module taycos_chk
    import taycos_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                valid,
    input logic signed [29:0]  cosine,
    input logic [4:0]          terms_used,
    input logic                not_converged
);

    a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $past(start && !busy, PIPE_LAT))
        else $error("result without a matching item");

    a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##PIPE_LAT valid)
        else $error("item lost in the pipeline");

    a_terms_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (terms_used >= 5'd1 && terms_used <= 5'(MAX_TERMS)))
        else $error("terms_used out of range");

    a_nc_full: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && not_converged) |-> (terms_used == 5'(MAX_TERMS)))
        else $error("not_converged before the term limit");

    a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (cosine <= 30'sd268435456 && cosine >= -30'sd268435456))
        else $error("cosine beyond plus or minus one");

endmodule

bind taylor_cosine_converge_top taycos_chk u_taycos_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .valid         (valid),
    .cosine        (cosine),
    .terms_used    (terms_used),
    .not_converged (not_converged)
);

/* dv/tb_taylor_cosine_converge_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_taylor_cosine_converge_top
// Drives angles through the Taylor series cosine block under several
// precision settings and checks cosine, terms_used and not_converged against
// a bit-exact fixed-point series model kept in the testbench.
// ----------------------------------------------------------------------------
module tb_taylor_cosine_converge_top;
    import taycos_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = PIPE_LAT + 8;

    typedef struct packed {
        logic signed [29:0] cos_q;
        logic [4:0]         n_terms;
        logic               no_conv;
    } cos_result_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] angle;
    logic               cfg_wr_en;
    logic signed [3:0]  cfg_wr_data;
    logic               valid;
    logic signed [29:0] cosine;
    logic [4:0]         terms_used;
    logic               not_converged;

    cos_result_t       cos_expected_q[$];
    logic signed [3:0] prec_exp;
    bit                idle_en;
    int                err_cnt;
    int                quiet_cycles;

    taylor_cosine_converge_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .angle         (angle),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .valid         (valid),
        .cosine        (cosine),
        .terms_used    (terms_used),
        .not_converged (not_converged)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // product shifted down by the fraction bits, rounded half up
    function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b) + (128'd1 << (FRAC_BITS - 1));
        return 64'(p >> FRAC_BITS);
    endfunction

    function automatic logic [63:0] stop_level(input logic signed [3:0] p);
        logic [63:0] one_q;
        logic [63:0] den;
        int          k;
        one_q = 64'd1 << FRAC_BITS;
        den   = 64'd1;
        if (p >= 0)
        begin
            for (k = 0; k < p; k++)
                one_q = one_q * 10;
            return one_q;
        end
        for (k = 0; k < -p; k++)
            den = den * 10;
        return (one_q + den / 2) / den;
    endfunction

    function automatic cos_result_t cosine_series(input logic [31:0] ang,
                                                  input logic signed [3:0] p);
        cos_result_t       r;
        logic [63:0]       mag;
        logic [63:0]       x2;
        logic [63:0]       term;
        logic [63:0]       thr;
        logic [63:0]       dd;
        logic [63:0]       recip;
        logic signed [63:0] sum;
        logic signed [63:0] one_q;
        int                i;
        int                used;
        bit                conv;
        one_q = 64'sd1 <<< FRAC_BITS;
        mag = ang[31] ? (64'h1_0000_0000 - 64'(ang)) : 64'(ang);
        if (mag > (64'd1 << 30))
            mag = 64'd1 << 30;
        x2   = fx_mul(mag, mag);
        thr  = stop_level(p);
        term = 64'd1 << FRAC_BITS;
        sum  = one_q;
        used = 0;
        conv = 1'b0;
        for (i = 1; i <= MAX_TERMS; i++)
        begin
            dd    = 64'((2 * i - 1) * (2 * i));
            recip = ((64'd1 << FRAC_BITS) + dd / 2) / dd;
            term  = fx_mul(fx_mul(term, x2), recip);
            if (i % 2)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
            used = i;
            if (term <= thr)
            begin
                conv = 1'b1;
                break;
            end
        end
        if (sum > one_q)
            sum = one_q;
        if (sum < -one_q)
            sum = -one_q;
        r.cos_q   = sum[29:0];
        r.n_terms = 5'(used > 31 ? 31 : used);
        r.no_conv = !conv;
        return r;
    endfunction

    task automatic send_angle(input logic [31:0] a);
        while (idle_en && $urandom_range(99) < 22)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        angle <= a;
        do
            @(posedge clk);
        while (busy);
        quiet_cycles = 0;
        cos_expected_q.push_back(cosine_series(a, prec_exp));
    endtask

    // lets the pipe drain, then writes the precision register
    task automatic set_precision(input logic signed [3:0] p);
        start <= 1'b0;
        @(posedge clk);
        while (cos_expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= p;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        prec_exp = p;
        quiet_cycles = 0;
    endtask

    function automatic logic [31:0] rand_angle();
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return $urandom_range(1) ? 32'h4000_0000 : 32'hC000_0000;
            default: return 32'($signed($urandom_range(32'h8000_0000)) - 32'sh4000_0000);
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] pts[$];
        pts = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h4000_0000, 32'hC000_0000,
                32'h4000_0001, 32'hBFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                32'd843314857, -32'sd843314857, 32'd421657428, 32'd1686629713,
                32'h1000_0000, 32'h5555_5555, 32'hAAAA_AAAA};
        foreach (pts[k])
            send_angle(pts[k]);
    endtask

    task automatic test_precision_sweep();
        logic signed [3:0] p;
        for (int e = -8; e <= 7; e++)
        begin
            p = 4'(e);
            set_precision(p);
            send_angle(32'h4000_0000);
            send_angle(32'h0800_0000);
            send_angle(rand_angle());
        end
    endtask

    task automatic test_random();
        logic signed [3:0] plist[$];
        plist = '{-4'sd3, -4'sd8, -4'sd1, 4'sd7, 4'sd0, -4'sd5};
        foreach (plist[k])
        begin
            set_precision(plist[k]);
            idle_en = (k != 2);
            repeat (65) send_angle(rand_angle());
        end
        idle_en = 1'b1;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && valid)
        begin
            if (cos_expected_q.size() == 0)
            begin
                $error("result with nothing expected: cosine %0d", cosine);
                err_cnt++;
            end
            else
            begin
                cos_result_t e;
                e = cos_expected_q.pop_front();
                if (cosine !== e.cos_q)
                begin
                    $error("cosine: expected %0d, got %0d", e.cos_q, cosine);
                    err_cnt++;
                end
                if (terms_used !== e.n_terms)
                begin
                    $error("terms_used: expected %0d, got %0d", e.n_terms, terms_used);
                    err_cnt++;
                end
                if (not_converged !== e.no_conv)
                begin
                    $error("not_converged: expected %0d, got %0d", e.no_conv,
                           not_converged);
                    err_cnt++;
                end
            end
            quiet_cycles = 0;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_taylor_cosine_converge_top: errors");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        angle        = '0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        prec_exp     = -4'sd3;
        idle_en      = 1'b1;
        err_cnt      = 0;
        quiet_cycles = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_precision_sweep();
        test_random();

        start <= 1'b0;
        @(posedge clk);
        while (cos_expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("tb_taylor_cosine_converge_top: clean");
        else
            $display("tb_taylor_cosine_converge_top: errors");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/taycos_pkg.sv
hw/rtl/taylor_cosine_converge_top.sv
hw/rtl/taycos_chk.sv
dv/tb_taylor_cosine_converge_top.sv
